/* rtl/sorted_cursor_list_insert_remove_macros.svh */
// Assertion helpers used by the port checker file.
// Each macro samples on the rising edge of clk and is off while rst_n is low.
`ifndef SORTED_CURSOR_LIST_INSERT_REMOVE_MACROS_SVH
`define SORTED_CURSOR_LIST_INSERT_REMOVE_MACROS_SVH

// Same-cycle implication
`define SCL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("port check failed");

// Next-cycle implication
`define SCL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("port check failed");

`endif

/* rtl/scl_pkg.sv */
`default_nettype none
package scl_pkg;

    // Pool geometry: nodes 1..NODES, node 0 is null
    localparam int NODES = 15;
    localparam int DEPTH = NODES + 1;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int KEY_W = 32;

    typedef logic [IDX_W-1:0] idx_t;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_REMOVED   = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    typedef struct packed {
        logic                    command;
        logic signed [KEY_W-1:0] value;
    } req_t;

    typedef struct packed {
        status_t    status;
        logic [3:0] node_index;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FREE_CAP,
        S_CMP,
        S_DECIDE,
        S_WR_A,
        S_WR_B
    } state_t;

    typedef struct packed {
        logic                    en;
        idx_t                    addr;
        logic signed [KEY_W-1:0] data;
    } val_wr_t;

    typedef struct packed {
        logic en;
        idx_t addr;
        idx_t data;
    } link_wr_t;

endpackage
`default_nettype wire

/* rtl/scl_value_ram.sv */
`default_nettype none
module scl_value_ram (
    input  wire                                      clk,
    input  scl_pkg::idx_t                            rd_addr,
    input  scl_pkg::val_wr_t                         wr,
    output logic signed [scl_pkg::KEY_W-1:0]         rd_data
);

    logic signed [scl_pkg::KEY_W-1:0] mem [scl_pkg::DEPTH];
    logic signed [scl_pkg::KEY_W-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

/* rtl/scl_link_ram.sv */
`default_nettype none
module scl_link_ram (
    input  wire               clk,
    input  wire               rst_n,
    input  scl_pkg::idx_t     rd_addr,
    input  scl_pkg::link_wr_t wr,
    output scl_pkg::idx_t     rd_data
);

    scl_pkg::idx_t              mem [scl_pkg::DEPTH];
    scl_pkg::idx_t              rd_data_reg;
    scl_pkg::idx_t              rd_addr_reg;
    logic [scl_pkg::DEPTH-1:0]  valid_reg;
    logic                       hit_reg;
    scl_pkg::idx_t              reset_link;

    // Track written entries; unwritten ones read as their reset chain link
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            hit_reg <= valid_reg[rd_addr];
        end
    end

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
        rd_addr_reg <= rd_addr;
    end

    // Reset chain: entry i links to i+1, the last node links to null
    assign reset_link = (rd_addr_reg == scl_pkg::IDX_W'(scl_pkg::NODES)) ? '0
                      : rd_addr_reg + scl_pkg::idx_t'(1);
    assign rd_data    = hit_reg ? rd_data_reg : reset_link;

endmodule
`default_nettype wire

/* rtl/sorted_cursor_list_insert_remove.sv */
`default_nettype none
// Sorted cursor list: an ascending, duplicate-free list of signed 32-bit
// keys held in a pool of 15 nodes linked by index, plus a free-node chain.
//
// Request channel: drive request (command, value) with start high; the beat
// is taken at a rising edge where busy is low. busy stays high until the
// operation completes.
// Result channel: done pulses for exactly one cycle with result (status,
// node_index). The receiver cannot stall; it must take the beat that cycle.
// The next request may be started in the same cycle that done is shown.
//
// Steps: an insert first fetches the successor of the free head
// (S_FREE_CAP); both commands then walk the list (S_CMP), decide (S_DECIDE)
// and, for a completed insert or remove, write back (S_WR_A, S_WR_B). A
// duplicate, full or not-found outcome ends at S_DECIDE. The walk reads one
// node per cycle through the node memories' single read port (0..15 nodes).
//
// Reset: the list is empty and the free chain holds nodes 1..15 in order.
// No clearing pass is needed; reset takes effect at once.
module sorted_cursor_list_insert_remove (
    input  wire           clk,
    input  wire           rst_n,
    input  wire           start,
    output logic          busy,
    input  scl_pkg::req_t request,
    output logic          done,
    output scl_pkg::rsp_t result
);

    scl_pkg::state_t state_reg, state_next;
    logic            cmd_reg, cmd_next;
    logic signed [scl_pkg::KEY_W-1:0] key_reg, key_next;
    scl_pkg::idx_t   cur_reg, cur_next;
    scl_pkg::idx_t   prev_reg, prev_next;
    scl_pkg::idx_t   cur_link_reg, cur_link_next;
    scl_pkg::idx_t   free_next_reg, free_next_next;
    logic            stop_reg, stop_next;
    logic            eq_reg, eq_next;
    scl_pkg::idx_t   head_reg, head_next;
    scl_pkg::idx_t   free_head_reg, free_head_next;
    scl_pkg::rsp_t   result_reg, result_next;
    logic            done_reg, done_next;

    scl_pkg::idx_t     rd_addr;
    scl_pkg::val_wr_t  val_wr;
    scl_pkg::link_wr_t link_wr;
    logic signed [scl_pkg::KEY_W-1:0] rd_value;
    scl_pkg::idx_t     rd_link;
    logic              found;

    scl_value_ram u_value_ram (
        .clk     (clk),
        .rd_addr (rd_addr),
        .wr      (val_wr),
        .rd_data (rd_value)
    );

    scl_link_ram u_link_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .wr      (link_wr),
        .rd_data (rd_link)
    );

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= scl_pkg::S_IDLE;
            head_reg      <= '0;
            free_head_reg <= scl_pkg::idx_t'(1);
            done_reg      <= 1'b0;
            stop_reg      <= 1'b0;
            eq_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            free_head_reg <= free_head_next;
            done_reg      <= done_next;
            stop_reg      <= stop_next;
            eq_reg        <= eq_next;
        end
    end

    // Working registers of one operation
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        key_reg       <= key_next;
        cur_reg       <= cur_next;
        prev_reg      <= prev_next;
        cur_link_reg  <= cur_link_next;
        free_next_reg <= free_next_next;
        result_reg    <= result_next;
    end

    assign found = stop_reg && eq_reg;

    // Sequencer: walk, decide, write back
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        cur_link_next  = cur_link_reg;
        free_next_next = free_next_reg;
        stop_next      = stop_reg;
        eq_next        = eq_reg;
        head_next      = head_reg;
        free_head_next = free_head_reg;
        result_next    = result_reg;
        done_next      = 1'b0;
        rd_addr        = cur_reg;
        val_wr         = '0;
        link_wr        = '0;

        case (state_reg)
            scl_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd_next  = request.command;
                    key_next  = request.value;
                    prev_next = '0;
                    cur_next  = head_reg;
                    stop_next = 1'b0;
                    eq_next   = 1'b0;
                    if (request.command == scl_pkg::CMD_INSERT)
                    begin
                        // fetch the successor of the free head first
                        rd_addr    = free_head_reg;
                        state_next = scl_pkg::S_FREE_CAP;
                    end
                    else
                    begin
                        rd_addr    = head_reg;
                        state_next = (head_reg == '0) ? scl_pkg::S_DECIDE : scl_pkg::S_CMP;
                    end
                end
            end

            scl_pkg::S_FREE_CAP:
            begin
                free_next_next = rd_link;
                rd_addr        = head_reg;
                state_next     = (head_reg == '0) ? scl_pkg::S_DECIDE : scl_pkg::S_CMP;
            end

            scl_pkg::S_CMP:
            begin
                if (key_reg > rd_value)
                begin
                    // advance past a smaller key
                    prev_next = cur_reg;
                    cur_next  = rd_link;
                    rd_addr   = rd_link;
                    if (rd_link == '0)
                    begin
                        state_next = scl_pkg::S_DECIDE;
                    end
                end
                else
                begin
                    stop_next     = 1'b1;
                    eq_next       = (key_reg == rd_value);
                    cur_link_next = rd_link;
                    state_next    = scl_pkg::S_DECIDE;
                end
            end

            scl_pkg::S_DECIDE:
            begin
                state_next = scl_pkg::S_IDLE;
                done_next  = 1'b1;
                result_next.node_index = '0;
                if (cmd_reg == scl_pkg::CMD_INSERT)
                begin
                    if (found)
                    begin
                        result_next.status = scl_pkg::ST_DUPLICATE;
                    end
                    else if (free_head_reg == '0)
                    begin
                        result_next.status = scl_pkg::ST_FULL;
                    end
                    else
                    begin
                        done_next  = 1'b0;
                        state_next = scl_pkg::S_WR_A;
                    end
                end
                else
                begin
                    if (!found)
                    begin
                        result_next.status = scl_pkg::ST_NOT_FOUND;
                    end
                    else
                    begin
                        done_next  = 1'b0;
                        state_next = scl_pkg::S_WR_A;
                    end
                end
            end

            scl_pkg::S_WR_A:
            begin
                state_next = scl_pkg::S_WR_B;
                if (cmd_reg == scl_pkg::CMD_INSERT)
                begin
                    // fill the new node and point it at the stopping node
                    val_wr.en    = 1'b1;
                    val_wr.addr  = free_head_reg;
                    val_wr.data  = key_reg;
                    link_wr.en   = 1'b1;
                    link_wr.addr = free_head_reg;
                    link_wr.data = stop_reg ? cur_reg : '0;
                end
                else
                begin
                    // push the removed node onto the free chain
                    link_wr.en   = 1'b1;
                    link_wr.addr = cur_reg;
                    link_wr.data = free_head_reg;
                end
            end

            scl_pkg::S_WR_B:
            begin
                state_next = scl_pkg::S_IDLE;
                done_next  = 1'b1;
                if (cmd_reg == scl_pkg::CMD_INSERT)
                begin
                    if (prev_reg == '0)
                    begin
                        head_next = free_head_reg;
                    end
                    else
                    begin
                        link_wr.en   = 1'b1;
                        link_wr.addr = prev_reg;
                        link_wr.data = free_head_reg;
                    end
                    free_head_next         = free_next_reg;
                    result_next.status     = scl_pkg::ST_INSERTED;
                    result_next.node_index = 4'(free_head_reg);
                end
                else
                begin
                    // unlink the removed node
                    if (prev_reg == '0)
                    begin
                        head_next = cur_link_reg;
                    end
                    else
                    begin
                        link_wr.en   = 1'b1;
                        link_wr.addr = prev_reg;
                        link_wr.data = cur_link_reg;
                    end
                    free_head_next         = cur_reg;
                    result_next.status     = scl_pkg::ST_REMOVED;
                    result_next.node_index = 4'(cur_reg);
                end
            end

            default:
            begin
                state_next = scl_pkg::S_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != scl_pkg::S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire

/* rtl/scl_port_checker.sv */
`default_nettype none
`include "sorted_cursor_list_insert_remove_macros.svh"
module scl_port_checker (
    input wire           clk,
    input wire           rst_n,
    input wire           start,
    input wire           busy,
    input wire           done,
    input scl_pkg::rsp_t result
);

    logic err_beat;
    logic ok_beat;

    // Sort result beats into error and success outcomes
    assign err_beat = done && (result.status inside {scl_pkg::ST_DUPLICATE,
                                                     scl_pkg::ST_NOT_FOUND,
                                                     scl_pkg::ST_FULL});
    assign ok_beat  = done && (result.status inside {scl_pkg::ST_INSERTED,
                                                     scl_pkg::ST_REMOVED});

    // Error outcomes never name a node
    `SCL_ASSERT_NOW(a_err_no_node, err_beat, result.node_index == 4'd0)

    // Successful outcomes name a real node
    `SCL_ASSERT_NOW(a_ok_has_node, ok_beat, result.node_index != 4'd0)

    // A result beat shows only once the block is free again
    `SCL_ASSERT_NOW(a_done_not_busy, done, !busy)

    // An accepted beat keeps the block busy in the next cycle
    `SCL_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done)

endmodule

bind sorted_cursor_list_insert_remove scl_port_checker u_scl_port_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
`default_nettype wire
